// ===== rtl/core/tea_pkg.sv =====
// shared types and constants for the tea block cipher
// no dependencies
`default_nettype none

package tea_pkg;

  localparam int unsigned TEA_WORD_W = 32;
  localparam int unsigned TEA_SHL = 4;
  localparam int unsigned TEA_SHR = 5;

  // depth of the queue between front and back, power of two
  localparam int unsigned TEA_QUEUE_DEPTH = 4;

  // apb register map, index = paddr[4:2]
  localparam int unsigned TEA_ADDR_W = 5;
  localparam int unsigned TEA_IDX_W = 3;
  localparam logic [TEA_IDX_W-1:0] TEA_REG_KEY0  = 3'd0;
  localparam logic [TEA_IDX_W-1:0] TEA_REG_KEY1  = 3'd1;
  localparam logic [TEA_IDX_W-1:0] TEA_REG_KEY2  = 3'd2;
  localparam logic [TEA_IDX_W-1:0] TEA_REG_KEY3  = 3'd3;
  localparam logic [TEA_IDX_W-1:0] TEA_REG_DELTA = 3'd4;

  localparam logic [TEA_WORD_W-1:0] TEA_DELTA_RESET = 32'h9E37_79B9;

  typedef struct packed {
    logic [TEA_WORD_W-1:0] key0;
    logic [TEA_WORD_W-1:0] key1;
    logic [TEA_WORD_W-1:0] key2;
    logic [TEA_WORD_W-1:0] key3;
    logic [TEA_WORD_W-1:0] delta;
  } tea_cfg_t;

  typedef struct packed {
    logic                  decrypt;
    logic [TEA_WORD_W-1:0] left;
    logic [TEA_WORD_W-1:0] right;
    logic [TEA_WORD_W-1:0] sum;
  } tea_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/tea_block_cipher_unit.sv =====
// tea block cipher: front end, transaction queue, round pipeline, apb registers
// path: an accepted input goes through the queue and then the round pipeline to the output
// throughput: one transaction per cycle while the output is taken, one half-round per pipeline stage
// reset: key words clear to zero, round constant to 0x9E3779B9, queue and pipeline empty
// depends on tea_pkg, tea_front, tea_queue, tea_back
`default_nettype none

module tea_block_cipher_unit import tea_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [TEA_ADDR_W-1:0] paddr,
  input  wire logic [TEA_WORD_W-1:0] pwdata,
  output logic [TEA_WORD_W-1:0]      prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  req_type_i,
  input  wire logic [TEA_WORD_W-1:0] left_half_i,
  input  wire logic [TEA_WORD_W-1:0] right_half_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [TEA_WORD_W-1:0]      out_left_o,
  output logic [TEA_WORD_W-1:0]      out_right_o
);

  logic [TEA_WORD_W-1:0] key0_q, key1_q, key2_q, key3_q, delta_q;
  logic [TEA_IDX_W-1:0]  reg_idx;
  logic                  reg_write;
  tea_cfg_t              cfg;
  tea_item_t             front_item;
  tea_item_t             head_item;
  logic                  push, pop, queue_full, head_valid;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[TEA_ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      delta_q <= TEA_DELTA_RESET;
    end else if (reg_write) begin
      case (reg_idx)
        TEA_REG_KEY0:  key0_q  <= pwdata;
        TEA_REG_KEY1:  key1_q  <= pwdata;
        TEA_REG_KEY2:  key2_q  <= pwdata;
        TEA_REG_KEY3:  key3_q  <= pwdata;
        TEA_REG_DELTA: delta_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      TEA_REG_KEY0:  prdata = key0_q;
      TEA_REG_KEY1:  prdata = key1_q;
      TEA_REG_KEY2:  prdata = key2_q;
      TEA_REG_KEY3:  prdata = key3_q;
      TEA_REG_DELTA: prdata = delta_q;
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg.key0  = key0_q;
    cfg.key1  = key1_q;
    cfg.key2  = key2_q;
    cfg.key3  = key3_q;
    cfg.delta = delta_q;
  end

  tea_front #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .left_half_i  (left_half_i),
    .right_half_i (right_half_i),
    .cfg_i        (cfg),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  tea_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  tea_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_left_o   (out_left_o),
    .out_right_o  (out_right_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tea_queue.sv =====
// short fifo of classified transactions between front and back
// depends on tea_pkg
`default_nettype none

module tea_queue import tea_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire tea_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output tea_item_t      item_o
);

  localparam int unsigned PtrW = (TEA_QUEUE_DEPTH > 1) ? $clog2(TEA_QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TEA_QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(TEA_QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TEA_QUEUE_DEPTH);

  tea_item_t       entry_q [TEA_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tea_front.sv =====
// front end: accepts input transactions, picks the mode and the starting sum
// depends on tea_pkg
`default_nettype none

module tea_front import tea_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  req_type_i,
  input  wire logic [TEA_WORD_W-1:0] left_half_i,
  input  wire logic [TEA_WORD_W-1:0] right_half_i,
  input  wire tea_cfg_t              cfg_i,
  input  wire logic                  queue_full_i,
  output logic                       push_o,
  output tea_item_t                  item_o
);

  logic [TEA_WORD_W-1:0] sum_total;

  // decryption walks the sum down from delta * rounds
  assign sum_total = cfg_i.delta * TEA_WORD_W'(ROUND_COUNT);

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    item_o.decrypt = req_type_i;
    item_o.left    = left_half_i;
    item_o.right   = right_half_i;
    // encryption adds delta ahead of each round, so the first round sees delta
    item_o.sum     = req_type_i ? sum_total : cfg_i.delta;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tea_back.sv =====
// back end: round pipeline, one half-round per stage, last stage is the output register
// depends on tea_pkg
`default_nettype none

module tea_back import tea_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tea_cfg_t              cfg_i,
  input  wire logic                  head_valid_i,
  input  wire tea_item_t             head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [TEA_WORD_W-1:0]      out_left_o,
  output logic [TEA_WORD_W-1:0]      out_right_o
);

  localparam int unsigned Stages = 2 * ROUND_COUNT;

  function automatic logic [TEA_WORD_W-1:0] tea_mix(
    input logic [TEA_WORD_W-1:0] x,
    input logic [TEA_WORD_W-1:0] sum,
    input logic [TEA_WORD_W-1:0] ka,
    input logic [TEA_WORD_W-1:0] kb
  );
    return ((x << TEA_SHL) + ka) ^ (x + sum) ^ ((x >> TEA_SHR) + kb);
  endfunction

  // even stages: first half-update of a round, odd stages: second one
  function automatic tea_item_t half_update(
    input tea_item_t it,
    input logic      odd,
    input tea_cfg_t  cfg
  );
    tea_item_t             res;
    logic                  upd_left;
    logic [TEA_WORD_W-1:0] mix;
    res      = it;
    upd_left = (it.decrypt == odd);
    if (upd_left) begin
      mix      = tea_mix(it.right, it.sum, cfg.key0, cfg.key1);
      res.left = it.decrypt ? it.left - mix : it.left + mix;
    end else begin
      mix       = tea_mix(it.left, it.sum, cfg.key2, cfg.key3);
      res.right = it.decrypt ? it.right - mix : it.right + mix;
    end
    // sum steps once per round, off the data path
    if (odd) begin
      res.sum = it.decrypt ? it.sum - cfg.delta : it.sum + cfg.delta;
    end
    return res;
  endfunction

  tea_item_t         stage_in [Stages];
  tea_item_t         stage_q  [Stages];
  logic [Stages-1:0] valid_q;
  logic              advance;

  // whole pipeline moves unless the output holds a result not yet taken
  assign advance     = !valid_q[Stages-1] || out_ready_i;
  assign pop_o       = advance && head_valid_i;
  assign out_valid_o = valid_q[Stages-1];
  assign out_left_o  = stage_q[Stages-1].left;
  assign out_right_o = stage_q[Stages-1].right;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[Stages-2:0], head_valid_i};
    end
  end

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign stage_in[k] = head_i;
    end else begin : g_next
      assign stage_in[k] = stage_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        stage_q[k] <= half_update(stage_in[k], 1'(k % 2), cfg_i);
      end
    end
  end

endmodule

`default_nettype wire
